>>> rtl/dvh_pkg.sv
// Shared types and constants for the duplicate value histogram block.
`default_nettype none

package dvh_pkg;

    // Field widths fixed by the item formats.
    localparam int VALUE_W     = 6;
    localparam int OUT_COUNT_W = 16;

    // Default sizing of the count table.
    localparam int VALUE_SLOTS_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;

    // Largest count that the result field can carry.
    localparam int OUT_COUNT_MAX = 65535;

    // Reset value of the max_value register.
    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 6'd63;

    // One input item.
    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               last_item;
    } dvh_in_t;

    // One result item.
    typedef struct packed {
        logic [VALUE_W-1:0]     dup_value;
        logic [OUT_COUNT_W-1:0] dup_count;
        logic                   found;
        logic                   last_result;
    } dvh_out_t;

endpackage

`default_nettype wire

>>> rtl/duplicate_value_histogram_top.sv
// Top level of the duplicate value histogram: control, config register and RAM.
// Loading: one item per cycle while in_stall is low; an item's table entry is written in the
// cycle after it is accepted. Set end: input stalls after the last item (flush, a scan at one
// entry per cycle while results are not stalled, scan close), longer while results are stalled.
// Results leave through a registered output; the last result follows the scan end.
// Reset: a clearing pass zeroes the table; input stalls meanwhile.
`default_nettype none

module duplicate_value_histogram_top #(
    parameter int VALUE_SLOTS = dvh_pkg::VALUE_SLOTS_DEF,
    parameter int COUNT_BITS  = dvh_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire dvh_pkg::dvh_in_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output dvh_pkg::dvh_out_t                out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dvh_pkg::VALUE_W-1:0] cfg_data
);

    import dvh_pkg::*;

    localparam int AW = $clog2(VALUE_SLOTS);

    typedef enum logic [1:0] {
        T_RUN,
        T_FLUSH,
        T_SCAN
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]  max_value_reg;

    logic                  accept;
    logic                  scan_busy;
    logic                  scan_start;

    logic                  cnt_rd_en, scan_rd_en, ram_rd_en;
    logic [AW-1:0]         cnt_rd_addr, scan_rd_addr, ram_rd_addr;
    logic                  cnt_wr_en, scan_wr_en, ram_wr_en;
    logic [AW-1:0]         cnt_wr_addr, scan_wr_addr, ram_wr_addr;
    logic [COUNT_BITS-1:0] cnt_wr_data, scan_wr_data, ram_wr_data;
    logic [COUNT_BITS-1:0] ram_rd_data;

    // Input is taken only while loading and no sweep is running.
    assign in_stall   = (state_reg != T_RUN) || scan_busy;
    assign accept     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign scan_start = (state_reg == T_FLUSH);

    // The sweeper owns the RAM ports while it is busy.
    assign ram_rd_en   = scan_busy ? scan_rd_en   : cnt_rd_en;
    assign ram_rd_addr = scan_busy ? scan_rd_addr : cnt_rd_addr;
    assign ram_wr_en   = scan_busy ? scan_wr_en   : cnt_wr_en;
    assign ram_wr_addr = scan_busy ? scan_wr_addr : cnt_wr_addr;
    assign ram_wr_data = scan_busy ? scan_wr_data : cnt_wr_data;

    // Set control: the flush state lets the last item's update land before the scan.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_RUN:
            begin
                if (accept && in_data.last_item)
                begin
                    state_next = T_FLUSH;
                end
            end
            T_FLUSH:
            begin
                state_next = T_SCAN;
            end
            T_SCAN:
            begin
                if (!scan_busy)
                begin
                    state_next = T_RUN;
                end
            end
            default:
            begin
                state_next = T_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_RUN;
            max_value_reg <= MAX_VALUE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                max_value_reg <= cfg_data;
            end
        end
    end

    dvh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dvh_count #(
        .VALUE_SLOTS (VALUE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (in_data),
        .max_value (max_value_reg),
        .rd_en     (cnt_rd_en),
        .rd_addr   (cnt_rd_addr),
        .rd_data   (ram_rd_data),
        .wr_en     (cnt_wr_en),
        .wr_addr   (cnt_wr_addr),
        .wr_data   (cnt_wr_data)
    );

    dvh_scan #(
        .VALUE_SLOTS (VALUE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .max_value (max_value_reg),
        .busy      (scan_busy),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .rd_data   (ram_rd_data),
        .wr_en     (scan_wr_en),
        .wr_addr   (scan_wr_addr),
        .wr_data   (scan_wr_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/dvh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module dvh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dvh_count.sv
// Read-modify-write path that increments one table entry per accepted item that is counted.
`default_nettype none

module dvh_count #(
    parameter int VALUE_SLOTS = 64,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire dvh_pkg::dvh_in_t               sample,
    input  wire logic [dvh_pkg::VALUE_W-1:0]    max_value,
    output logic                                rd_en,
    output logic [$clog2(VALUE_SLOTS)-1:0]      rd_addr,
    input  wire logic [COUNT_BITS-1:0]          rd_data,
    output logic                                wr_en,
    output logic [$clog2(VALUE_SLOTS)-1:0]      wr_addr,
    output logic [COUNT_BITS-1:0]               wr_data
);

    import dvh_pkg::*;

    localparam int AW = $clog2(VALUE_SLOTS);
    localparam int KW = (AW + 1 > VALUE_W) ? AW + 1 : VALUE_W;

    logic                  counted;
    logic [AW-1:0]         addr;
    logic [COUNT_BITS-1:0] operand;

    logic                  s1_valid_reg, s1_valid_next;
    logic [AW-1:0]         s1_addr_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // A value is counted only when it is within the limit and the table.
    assign counted = (KW'(sample.sample_value) <= KW'(max_value)) &&
                     (KW'(sample.sample_value) < KW'(VALUE_SLOTS));
    assign addr    = AW'(sample.sample_value);

    assign rd_en   = accept && counted;
    assign rd_addr = addr;

    // Second stage: the entry read last cycle, or the value just written to it.
    assign operand = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_addr_reg;
    assign wr_data = (operand == {COUNT_BITS{1'b1}}) ? operand
                                                     : operand + COUNT_BITS'(1);

    // The RAM returns stale data when the same entry is written in the read cycle.
    assign s1_valid_next = accept && counted;
    assign fwd_hit_next  = accept && counted && s1_valid_reg && (s1_addr_reg == addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= addr;
        fwd_data_reg <= wr_data;
    end

endmodule

`default_nettype wire

>>> rtl/dvh_scan.sv
// Table sweeper: clears after reset and scans for duplicates at set end.
`default_nettype none

module dvh_scan #(
    parameter int VALUE_SLOTS = 64,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [dvh_pkg::VALUE_W-1:0]    max_value,
    output logic                                busy,
    output logic                                rd_en,
    output logic [$clog2(VALUE_SLOTS)-1:0]      rd_addr,
    input  wire logic [COUNT_BITS-1:0]          rd_data,
    output logic                                wr_en,
    output logic [$clog2(VALUE_SLOTS)-1:0]      wr_addr,
    output logic [COUNT_BITS-1:0]               wr_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output dvh_pkg::dvh_out_t                   out_data
);

    import dvh_pkg::*;

    localparam int AW  = $clog2(VALUE_SLOTS);
    localparam int PW  = AW + 1;
    localparam int LW  = (AW > VALUE_W) ? AW : VALUE_W;
    localparam int CEW = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    typedef enum logic [1:0] {
        SC_CLEAR,
        SC_IDLE,
        SC_SCAN,
        SC_FINISH
    } scan_state_t;

    scan_state_t           state_reg, state_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic                  sv_reg, sv_next;
    logic [AW-1:0]         sa_reg, sa_next;
    logic                  pv_reg, pv_next;
    logic [AW-1:0]         pa_reg, pa_next;
    logic [COUNT_BITS-1:0] pc_reg, pc_next;
    logic                  ov_reg, ov_next;
    dvh_out_t              od_reg, od_next;

    logic [LW-1:0] limit;
    logic          ptr_end;
    logic          o_free;
    logic          dup;
    logic          consume;
    logic          advance;
    logic          issue;

    // Builds a result item, clipping the count to the result field.
    function automatic dvh_out_t make_out(input logic [AW-1:0] value,
                                          input logic [COUNT_BITS-1:0] count,
                                          input logic found,
                                          input logic last);
        dvh_out_t     r;
        logic [CEW-1:0] ext;
        ext           = CEW'(count);
        r.dup_value   = VALUE_W'(value);
        r.dup_count   = (ext > CEW'(OUT_COUNT_MAX)) ? {OUT_COUNT_W{1'b1}}
                                                    : ext[OUT_COUNT_W-1:0];
        r.found       = found;
        r.last_result = last;
        return r;
    endfunction

    // Scan limit, capped at the last table entry.
    assign limit = (LW'(max_value) > LW'(VALUE_SLOTS - 1)) ? LW'(VALUE_SLOTS - 1)
                                                           : LW'(max_value);

    assign ptr_end = (ptr_reg == PW'(VALUE_SLOTS));
    assign o_free  = !ov_reg || !out_stall;

    // The entry held in the read stage is a duplicate within the limit.
    assign dup     = sv_reg && (LW'(sa_reg) <= limit) && (rd_data > COUNT_BITS'(1));
    assign consume = sv_reg && (!dup || !pv_reg || o_free);
    assign advance = !sv_reg || consume;
    assign issue   = (state_reg == SC_SCAN) && !ptr_end && advance;

    assign rd_en   = issue;
    assign rd_addr = ptr_reg[AW-1:0];

    // Clearing writes sweep the pointer; scan writes clear each entry as it retires.
    always_comb
    begin
        wr_data = '0;
        if (state_reg == SC_CLEAR)
        begin
            wr_en   = !ptr_end;
            wr_addr = ptr_reg[AW-1:0];
        end
        else
        begin
            wr_en   = consume;
            wr_addr = sa_reg;
        end
    end

    assign busy      = (state_reg != SC_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Next-state logic for the sweep, the pending duplicate and the output register.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        sv_next    = sv_reg;
        sa_next    = sa_reg;
        pv_next    = pv_reg;
        pa_next    = pa_reg;
        pc_next    = pc_reg;
        ov_next    = ov_reg && out_stall;
        od_next    = od_reg;

        case (state_reg)
            SC_CLEAR:
            begin
                if (ptr_end)
                begin
                    state_next = SC_IDLE;
                    ptr_next   = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = SC_SCAN;
                    ptr_next   = '0;
                    sv_next    = 1'b0;
                    pv_next    = 1'b0;
                end
            end
            SC_SCAN:
            begin
                // A new duplicate pushes the one held before it out as not last.
                if (consume && dup)
                begin
                    if (pv_reg)
                    begin
                        ov_next = 1'b1;
                        od_next = make_out(pa_reg, pc_reg, 1'b1, 1'b0);
                    end
                    pv_next = 1'b1;
                    pa_next = sa_reg;
                    pc_next = rd_data;
                end
                if (issue)
                begin
                    sv_next  = 1'b1;
                    sa_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + PW'(1);
                end
                else if (consume)
                begin
                    sv_next = 1'b0;
                end
                if (ptr_end && !sv_reg)
                begin
                    state_next = SC_FINISH;
                end
            end
            SC_FINISH:
            begin
                // Close the scan with the held duplicate or a none-found result.
                if (o_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = pv_reg ? make_out(pa_reg, pc_reg, 1'b1, 1'b1)
                                        : make_out('0, '0, 1'b0, 1'b1);
                    pv_next    = 1'b0;
                    state_next = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_CLEAR;
            ptr_reg   <= '0;
            sv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            sv_reg    <= sv_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        pa_reg <= pa_next;
        pc_reg <= pc_next;
        od_reg <= od_next;
    end

endmodule

`default_nettype wire

>>> rtl/dvh_checker.sv
// Port-level checks for the duplicate value histogram, bound to its top level.
`default_nettype none

module dvh_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire dvh_pkg::dvh_in_t            in_data,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire dvh_pkg::dvh_out_t           out_data,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [dvh_pkg::VALUE_W-1:0] cfg_data
);

    import dvh_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // The none-found result always closes its scan and carries zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |->
            out_data.last_result && (out_data.dup_value == '0) &&
            (out_data.dup_count == '0))
        else $error("malformed none-found result");

    // A reported duplicate was seen at least twice.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> (out_data.dup_count > OUT_COUNT_W'(1)))
        else $error("duplicate reported with count below two");

    // The item that ends a set is followed by a pause for the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.last_item |=> in_stall)
        else $error("input taken right after the last item of a set");

endmodule

bind duplicate_value_histogram_top dvh_checker u_dvh_checker (.*);

`default_nettype wire
